### rtl/core/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared widths and limits of the trial division prime counter.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpc_pkg;

    // Width of the candidate field as it arrives on the input channel.
    localparam int CAND_WIDTH = 32;

    // Default width of the tested part of the candidate.
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Running prime count and its saturation value.
    localparam int COUNT_WIDTH = 32;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Packed stream widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_WIDTH = ((CAND_WIDTH + 7) / 8) * 8;
    localparam int S_TUSER_WIDTH = 1;
    localparam int M_TDATA_WIDTH = ((1 + COUNT_WIDTH + 7) / 8) * 8;

endpackage : tdpc_pkg

`default_nettype wire

### rtl/core/trial_division_prime_counter_core.sv
// ----------------------------------------------------------------------------
// trial_division_prime_counter_core
// Tests candidates for primality by trial division with a bit-serial
// remainder unit and reports a saturating running count of primes.
// ----------------------------------------------------------------------------
// Usage
// The slave channel takes one candidate per transfer: tdata carries the
// candidate, tuser carries the clear flag, which zeroes the running count
// before this candidate is counted. The master channel returns one result
// per candidate: tdata bit 0 is the prime flag and the bits above it the
// running count including this candidate, which saturates at its maximum.
// Candidates below two and even candidates other than two are settled
// without trial division: the unit goes straight to its finish step,
// which loads the result into the output register once that is free.
// An odd candidate is divided by 3, 5, 7 and so on while the divisor
// squared does not exceed it. Each divisor takes one bound check, a
// division step for each of the W tested candidate bits, W being
// VALUE_WIDTH capped at the 32-bit candidate, in which the remainder unit
// shifts in that bit and conditionally subtracts, and one evaluation step.
// One candidate is worked on at a time; tready is high while the unit is
// idle. A finished result waits in the output register, so the next
// candidate may be taken while the receiver stalls; only the following
// completion waits for it. Reset clears the running count and empties the
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_counter_core #(
    parameter int VALUE_WIDTH = tdpc_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0 up: candidate[31:0].
    input  wire logic [tdpc_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    // Fields from bit 0 up: clear_count.
    input  wire logic [tdpc_pkg::S_TUSER_WIDTH-1:0] s_axis_tuser,
    // Result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // Fields from bit 0 up: is_prime, prime_count[31:0], zero padding.
    output logic [tdpc_pkg::M_TDATA_WIDTH-1:0]      m_axis_tdata
);

    import tdpc_pkg::*;

    // Tested width: only the candidate bits below both limits take part.
    localparam int CW = (VALUE_WIDTH < CAND_WIDTH) ? VALUE_WIDTH : CAND_WIDTH;
    // The last divisor tried stays below sqrt(2^CW) + 2, and the remainder
    // is always below the divisor.
    localparam int DW = (CW + 1) / 2 + 2;
    // Divisor squared overshoots the candidate by at most 4 * sqrt + 4.
    localparam int SW = CW + 2;
    // Bit counter of the remainder unit; it must hold CW itself.
    localparam int BW = $clog2(CW + 1);
    localparam int PADW = M_TDATA_WIDTH - 1 - COUNT_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_FINISH
    } t_state;

    // Control state.
    t_state                 r_state, n_state;
    logic                   r_m_valid, n_m_valid;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    // Payload registers.
    logic [CW-1:0]          r_cand, n_cand;
    logic [CW-1:0]          r_shift, n_shift;
    logic [DW-1:0]          r_div, n_div;
    logic [DW-1:0]          r_rem, n_rem;
    logic [SW-1:0]          r_sq, n_sq;
    logic [BW-1:0]          r_bits, n_bits;
    logic                   r_prime, n_prime;
    logic                   r_clr, n_clr;
    logic [COUNT_WIDTH-1:0] r_out_count, n_out_count;
    logic                   r_out_prime, n_out_prime;

    // Datapath of the remainder unit and the bound check.
    logic [CW-1:0]          w_in_cand;
    logic [DW:0]            w_trial;
    logic [DW:0]            w_diff;
    logic                   w_fits;
    logic                   w_past_bound;
    logic [SW-1:0]          w_sq_step;
    logic [COUNT_WIDTH-1:0] w_base_count;
    logic                   w_out_free;

    assign w_in_cand    = s_axis_tdata[CW-1:0];
    assign w_trial      = {r_rem, r_shift[CW-1]};
    assign w_diff       = w_trial - {1'b0, r_div};
    assign w_fits       = w_trial >= {1'b0, r_div};
    assign w_past_bound = r_sq > {{(SW-CW){1'b0}}, r_cand};
    // (d + 2)^2 = d^2 + 4d + 4.
    assign w_sq_step    = {{(SW-DW-2){1'b0}}, r_div, 2'b00} + SW'(4);
    assign w_base_count = r_clr ? '0 : r_count;
    assign w_out_free   = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_m_valid   = r_m_valid;
        n_count     = r_count;
        n_cand      = r_cand;
        n_shift     = r_shift;
        n_div       = r_div;
        n_rem       = r_rem;
        n_sq        = r_sq;
        n_bits      = r_bits;
        n_prime     = r_prime;
        n_clr       = r_clr;
        n_out_count = r_out_count;
        n_out_prime = r_out_prime;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cand = w_in_cand;
                    n_clr  = s_axis_tuser[0];
                    n_div  = DW'(3);
                    n_sq   = SW'(9);
                    priority if (w_in_cand < CW'(2)) begin
                        n_prime = 1'b0;
                        n_state = ST_FINISH;
                    end else if (w_in_cand == CW'(2)) begin
                        n_prime = 1'b1;
                        n_state = ST_FINISH;
                    end else if (!w_in_cand[0]) begin
                        n_prime = 1'b0;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (w_past_bound) begin
                    // No divisor up to the square root: prime.
                    n_prime = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    n_rem   = '0;
                    n_shift = r_cand;
                    n_bits  = BW'(CW);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem   = w_fits ? w_diff[DW-1:0] : w_trial[DW-1:0];
                n_shift = {r_shift[CW-2:0], 1'b0};
                n_bits  = r_bits - BW'(1);
                if (r_bits == BW'(1)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_rem == '0) begin
                    n_prime = 1'b0;
                    n_state = ST_FINISH;
                end else begin
                    n_div   = r_div + DW'(2);
                    n_sq    = r_sq + w_sq_step;
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_count = w_base_count;
                    if (r_prime && (w_base_count != COUNT_MAX)) begin
                        n_count = w_base_count + COUNT_WIDTH'(1);
                    end
                    n_out_count = n_count;
                    n_out_prime = r_prime;
                    n_m_valid   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_count   <= n_count;
        end
        r_cand      <= n_cand;
        r_shift     <= n_shift;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_sq        <= n_sq;
        r_bits      <= n_bits;
        r_prime     <= n_prime;
        r_clr       <= n_clr;
        r_out_count <= n_out_count;
        r_out_prime <= n_out_prime;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{PADW{1'b0}}, r_out_count, r_out_prime};

    // The remainder unit keeps its partial remainder below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    // Only odd divisors are ever tried.
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CHECK) || (r_state == ST_DIV) || (r_state == ST_EVAL))
        |-> r_div[0])
        else $error("even trial divisor");

    // An input transfer starts work, so the unit is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a candidate is in progress");

    // A prime result always carries a non-zero count.
    a_prime_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_out_prime) |-> (r_out_count != '0))
        else $error("prime reported with zero count");

endmodule : trial_division_prime_counter_core

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trial division prime counter core.
// ----------------------------------------------------------------------------
// A queue of pending candidates is filled at time zero: a short directed set
// covering the edge cases, then random candidates in four idling phases.
// A clocked driver offers them on the slave stream. A scoreboard mirrors the
// primality search and the saturating running count at every input transfer,
// then compares each result transfer field by field with the oldest
// prediction. Candidate sizes are kept in check, because an odd candidate
// costs about sqrt(n) / 2 divisors, each a full pass of the remainder unit.
// ----------------------------------------------------------------------------

module tb_top;

    import tdpc_pkg::*;

    // The instance keeps its default candidate width.
    localparam int VALUE_WIDTH = DEFAULT_VALUE_WIDTH;
    localparam logic [63:0] CAND_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    // Positions of the result fields in the master tdata.
    localparam int IS_PRIME_BIT = 0;
    localparam int COUNT_LSB    = 1;

    // Length of the receiver hold-off that backs the core up to its input.
    localparam int HOLD_CYCLES = 400;

    // In the slowest correct run of this stimulus, the longest search is that
    // of the directed 16777213, every random candidate that can reach a long
    // search stays below 65 536, and the idling adds little. The limit sits
    // well above that run.
    localparam int unsigned LIMIT_CYCLES = 2_000_000;

    // Cycles allowed after the last result for anything stray to appear.
    localparam int DRAIN_CYCLES = 100;

    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } t_idle_phase;

    typedef struct {
        logic [CAND_WIDTH-1:0] candidate;
        logic                  clear_count;
        t_idle_phase           phase;
        logic                  hold_off;
    } t_candidate_item;

    typedef struct packed {
        logic                   is_prime;
        logic [COUNT_WIDTH-1:0] prime_count;
    } t_prime_result;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // Fields from bit 0 up: candidate[31:0].
    logic [S_TDATA_WIDTH-1:0] s_axis_tdata  = '0;
    // Fields from bit 0 up: clear_count.
    logic [S_TUSER_WIDTH-1:0] s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // Fields from bit 0 up: is_prime, prime_count[31:0], zero padding.
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

    t_candidate_item  pending_q[$];
    t_prime_result    verdict_q[$];
    logic [COUNT_WIDTH-1:0] primes_seen = '0;
    t_idle_phase      idle_phase  = PH_STEADY;
    logic             hold_start  = 1'b0;
    int unsigned      hold_left   = 0;
    int unsigned      items_total = 0;
    int unsigned      items_taken = 0;
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;

    trial_division_prime_counter_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Primality by trial division. Only the low VALUE_WIDTH bits of the
    // candidate count. The bound d <= n / d is the overflow-free form of
    // d * d <= n, so squares of odd primes are caught at their root.
    function automatic logic prime_by_trial(input logic [CAND_WIDTH-1:0] raw);
        logic [63:0] n;
        logic [63:0] d;
        n = 64'(raw) & CAND_MASK;
        if (n < 64'd2) return 1'b0;
        if (n == 64'd2) return 1'b1;
        if (n[0] == 1'b0) return 1'b0;
        for (d = 64'd3; d <= n / d; d += 64'd2) begin
            if (n % d == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random candidates come in three sizes. Small and 16-bit ones may be
    // prime and exercise the full search; wide ones are given a factor of
    // 2, 3 or 5 so that the search ends at once yet every upper bit still
    // toggles.
    function automatic logic [CAND_WIDTH-1:0] random_candidate();
        logic [CAND_WIDTH-1:0] v;
        int unsigned           pick;
        v    = $urandom();
        pick = $urandom_range(99);
        if (pick < 40) begin
            v = v & 32'h0000_00FF;
        end else if (pick < 70) begin
            v = v & 32'h0000_FFFF;
        end else begin
            case ($urandom_range(2))
                0: begin
                    v[0] = 1'b0;
                end
                1: begin
                    v = v - (v % 3);
                end
                default: begin
                    v = v - (v % 5);
                end
            endcase
        end
        return v;
    endfunction

    task automatic add_item(input logic [CAND_WIDTH-1:0] cand, input logic clr,
                            input t_idle_phase ph, input logic hold);
        t_candidate_item item;
        item.candidate   = cand;
        item.clear_count = clr;
        item.phase       = ph;
        item.hold_off    = hold;
        pending_q.push_back(item);
        items_total++;
    endtask

    // Reset is held low from time zero and released once.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver. A new item is offered only once the previous one has been
    // taken, so tvalid stays high across back-to-back transfers without
    // being lowered and raised within the same step.
    always @(posedge i_clk) begin : driver
        t_candidate_item item;
        int unsigned     gap_pct;
        logic            hold_now;
        hold_now = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            gap_pct = 0;
            if (pending_q.size() != 0) begin
                case (pending_q[0].phase)
                    PH_SENDER_IDLE: gap_pct = 56;
                    PH_BOTH_IDLE:   gap_pct = 37;
                    default:        gap_pct = 0;
                endcase
            end
            if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                item = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= item.candidate;
                s_axis_tuser  <= item.clear_count;
                idle_phase    <= item.phase;
                hold_now       = item.hold_off;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        hold_start <= hold_now;
    end

    // The hold-off stretch is counted here, apart from the receiver, so the
    // sender keeps offering items while the core backs up behind a held result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : receiver
        int unsigned stall_pct;
        case (idle_phase)
            PH_RECEIVER_STALL: stall_pct = 56;
            PH_BOTH_IDLE:      stall_pct = 37;
            default:           stall_pct = 0;
        endcase
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !hold_start && hold_left == 0
                             && $urandom_range(99) >= stall_pct;
        end
    end

    // Scoreboard. Results are checked before the input transfer of the same
    // edge is predicted, so the order of both sides within a step is fixed.
    // The core works on one candidate at a time, so results come back in
    // input order and the running count can be followed at the input.
    always @(posedge i_clk) begin : scoreboard
        t_prime_result want;
        logic          verdict;
        if (!i_rst_n) begin
            primes_seen = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result transfer with nothing expected, tdata %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata[IS_PRIME_BIT] !== want.is_prime) begin
                        $error("is_prime: expected %0d, got %0d",
                               want.is_prime, m_axis_tdata[IS_PRIME_BIT]);
                        error_count++;
                    end
                    if (m_axis_tdata[COUNT_LSB +: COUNT_WIDTH] !== want.prime_count) begin
                        $error("prime_count: expected %0d, got %0d",
                               want.prime_count, m_axis_tdata[COUNT_LSB +: COUNT_WIDTH]);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                verdict = prime_by_trial(s_axis_tdata[CAND_WIDTH-1:0]);
                // A clear takes effect before this candidate is counted.
                if (s_axis_tuser[0]) primes_seen = '0;
                if (verdict && primes_seen != COUNT_MAX) begin
                    primes_seen = primes_seen + COUNT_WIDTH'(1);
                end
                verdict_q.push_back('{is_prime: verdict, prime_count: primes_seen});
                items_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned k;

        // Directed part. The first item starts the long receiver hold-off,
        // during which the following ones back the core up.
        add_item(32'd0,          1'b0, PH_STEADY, 1'b1);
        add_item(32'd1,          1'b0, PH_STEADY, 1'b0);
        add_item(32'd2,          1'b0, PH_STEADY, 1'b0);
        add_item(32'd3,          1'b0, PH_STEADY, 1'b0);
        add_item(32'd4,          1'b0, PH_STEADY, 1'b0);
        add_item(32'd5,          1'b0, PH_STEADY, 1'b0);
        // Squares of odd primes sit exactly on the divisor bound.
        add_item(32'd9,          1'b0, PH_STEADY, 1'b0);
        add_item(32'd25,         1'b0, PH_STEADY, 1'b0);
        add_item(32'd49,         1'b0, PH_STEADY, 1'b0);
        add_item(32'd289,        1'b0, PH_STEADY, 1'b0);
        // A clear together with a prime leaves the count at one.
        add_item(32'd7,          1'b1, PH_STEADY, 1'b0);
        add_item(32'd11,         1'b0, PH_STEADY, 1'b0);
        // A clear with a composite leaves the count at zero.
        add_item(32'd15,         1'b1, PH_STEADY, 1'b0);
        add_item(32'd65521,      1'b0, PH_STEADY, 1'b0);
        add_item(32'd65537,      1'b0, PH_STEADY, 1'b0);
        add_item(32'd1048573,    1'b0, PH_STEADY, 1'b0);
        add_item(32'd16777213,   1'b0, PH_STEADY, 1'b0);
        // Top of the range: all ones, the largest even value, a lone top
        // bit and the square of 65535, all with small factors.
        add_item(32'hFFFF_FFFF,  1'b0, PH_STEADY, 1'b0);
        add_item(32'hFFFF_FFFE,  1'b1, PH_STEADY, 1'b0);
        add_item(32'h8000_0000,  1'b0, PH_STEADY, 1'b0);
        add_item(32'hFFFE_0001,  1'b0, PH_STEADY, 1'b0);
        add_item(32'd97,         1'b0, PH_STEADY, 1'b0);

        // Random part, a quarter in each idling phase.
        for (k = 0; k < 80; k++) begin
            add_item(random_candidate(), $urandom_range(99) < 12,
                     t_idle_phase'(k / 20), 1'b0);
        end

        while (items_taken < items_total) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule : tb_top
